>>> sv/hfc_pkg.sv
// ----------------------------------------------------------------------------
// hfc_pkg
// Shared types and constants for the hex float to IEEE 754 converter.
// ----------------------------------------------------------------------------
package hfc_pkg;

  // configuration register indexes
  localparam logic CfgSrcIdx = 1'b0;
  localparam logic CfgDstIdx = 1'b1;

  // leading zero bits of a non-zero hex digit, two bits per digit value
  localparam logic [15:0] LzTable = 16'h55af;

  // rebiasing offsets, exponent counted in binary places
  localparam logic signed [10:0] BiasToSingle = 11'sd131;
  localparam logic [10:0]        BiasToDouble = 11'd765;
  localparam logic signed [10:0] SingleMaxExp = 11'sd254;
  localparam logic signed [10:0] SingleMinSub = -11'sd32;
  localparam logic [30:0]        SingleInf    = 31'h7f80_0000;

  // conversion mode held in the configuration registers
  typedef struct packed {
    logic src_dbl;
    logic dst_dbl;
  } cfg_t;

endpackage

>>> sv/hfc_convert.sv
// ----------------------------------------------------------------------------
// hfc_convert
// Combinational conversion of one hex float word to an IEEE 754 pattern.
// ----------------------------------------------------------------------------
module hfc_convert (
  input  hfc_pkg::cfg_t cfg,
  input  logic [63:0]   hex_word,
  output logic [63:0]   ieee_word
);

  logic [63:0]        w;
  logic               sgn;
  logic [6:0]         expt7;
  logic [55:0]        frac;
  logic [3:0]         nd;
  logic [55:0]        frac_d;
  logic [1:0]         lz;
  logic [55:0]        frac_n;
  logic signed [10:0] e_s;
  logic [10:0]        e_d;
  logic               ru_d;
  logic [54:0]        sum_d;
  logic [63:0]        res_d;
  logic               ru_n;
  logic [25:0]        sum_n;
  logic [31:0]        res_n;
  logic [4:0]         k;
  logic [23:0]        hi1;
  logic [23:0]        lost_mask;
  logic               ru_sub;
  logic [24:0]        sum_sub;
  logic [31:0]        res_s;

  // align a 32-bit source to the 64-bit layout
  assign w     = cfg.src_dbl ? hex_word : {hex_word[31:0], 32'b0};
  assign sgn   = w[63];
  assign expt7 = w[62:56];
  assign frac  = w[55:0];

  // leading zero hex digits, highest non-zero digit wins
  always_comb begin
    nd = 4'd0;
    for (int j = 0; j < 14; j++) begin
      if (frac[4*j +: 4] != 4'b0) begin
        nd = 4'(13 - j);
      end
    end
  end

  // normalise by digits, then by bits of the top digit
  assign frac_d = frac << {nd, 2'b00};
  assign lz     = 2'(hfc_pkg::LzTable >> {frac_d[55:52], 1'b0});
  assign frac_n = frac_d << lz;

  // rebiased exponents
  assign e_s = $signed({2'b0, expt7, 2'b00}) - $signed({5'b0, nd, 2'b00})
             - hfc_pkg::BiasToSingle - $signed({9'b0, lz});
  assign e_d = {2'b0, expt7, 2'b00} + hfc_pkg::BiasToDouble
             - {5'b0, nd, 2'b00} - {9'b0, lz};

  // double result, three bits rounded away
  assign ru_d  = frac_n[0] | frac_n[1] | frac_n[3];
  assign sum_d = {1'b0, frac_n[55:2]} + 55'(ru_d);
  assign res_d = {sgn, e_d, 52'b0} + {10'b0, sum_d[54:1]};

  // single normal result
  assign ru_n  = (|frac_n[30:0]) | frac_n[32];
  assign sum_n = {1'b0, frac_n[55:31]} + 26'(ru_n);
  assign res_n = {sgn, e_s[7:0], 23'b0} + {7'b0, sum_n[25:1]};

  // single subnormal result
  assign k         = ~e_s[4:0];
  assign hi1       = frac_n[55:32] >> k;
  assign lost_mask = ~(24'hff_ffff << k);
  assign ru_sub    = (|frac_n[31:0]) | (|(frac_n[55:32] & lost_mask)) | hi1[1];
  assign sum_sub   = {1'b0, hi1} + 25'(ru_sub);

  // single range selection
  always_comb begin
    if (e_s >= hfc_pkg::SingleMaxExp) begin
      res_s = {sgn, hfc_pkg::SingleInf};
    end else if (e_s >= 11'sd0) begin
      res_s = res_n;
    end else if (e_s >= hfc_pkg::SingleMinSub) begin
      res_s = {sgn, 7'b0, sum_sub[24:1]};
    end else begin
      res_s = {sgn, 31'b0};
    end
  end

  // zero fraction gives a signed zero, else the double or single result by mode
  always_comb begin
    if (frac == 56'b0) begin
      ieee_word = cfg.dst_dbl ? {sgn, 63'b0} : {32'b0, sgn, 31'b0};
    end else if (cfg.dst_dbl) begin
      ieee_word = res_d;
    end else begin
      ieee_word = {32'b0, res_s};
    end
  end

endmodule

>>> sv/hex_float_to_ieee754_converter_unit.sv
// ----------------------------------------------------------------------------
// hex_float_to_ieee754_converter_unit
// Converts hex float words (32 or 64 bit) to IEEE 754 single or double.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on in_valid / in_stall / in_hex_word, results leave on
//   out_valid / out_stall / out_ieee_word. A beat moves on a rising edge with
//   valid high and stall low. cfg_wr_en with cfg_index writes one mode bit
//   from cfg_wdata: index 0 selects a 64-bit source, index 1 a double result.
//   Change the mode only while no beat is in flight.
//   Each beat passes the input register, then the result register,
//   with the whole conversion in the logic between them. One beat is taken
//   every cycle while in_stall is low; the rate is set by that single
//   register-to-register pass. When the receiver stalls, the result register
//   holds and the input register still takes one more beat; in_stall rises
//   only once both are full. Reset empties both stages and selects a 32-bit
//   source and a single result.
// ----------------------------------------------------------------------------
module hex_float_to_ieee754_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_hex_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_ieee_word
);

  hfc_pkg::cfg_t cfg_r;
  logic          s1_valid_r;
  logic [63:0]   s1_word_r;
  logic          out_valid_r;
  logic [63:0]   out_word_r;
  logic [63:0]   conv_word;
  logic          out_hold;
  logic          s1_load;

  // mode registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hfc_pkg::CfgSrcIdx: cfg_r.src_dbl <= cfg_wdata;
        hfc_pkg::CfgDstIdx: cfg_r.dst_dbl <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_hold = out_valid_r & out_stall;
  assign in_stall = s1_valid_r & out_hold;
  assign s1_load  = ~s1_valid_r | ~out_hold;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_word_r <= in_hex_word;
    end
  end

  // conversion
  hfc_convert u_convert (
    .cfg       (cfg_r),
    .hex_word  (s1_word_r),
    .ieee_word (conv_word)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_hold) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_hold && s1_valid_r) begin
      out_word_r <= conv_word;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ieee_word = out_word_r;

endmodule

>>> sv/hfc_checker.sv
// ----------------------------------------------------------------------------
// hfc_checker
// Port-level checks for the hex float converter, bound to the top level.
// ----------------------------------------------------------------------------
module hfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_ieee_word
);

  // reset empties the result side
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input only stalls while a result is held back
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // an accepted beat reaches the output when the result register is free to take it
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !(out_valid && out_stall) |=> out_valid)
    else $error("accepted beat did not reach the output");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_ieee_word)))
    else $error("stalled result changed");

endmodule

bind hex_float_to_ieee754_converter_unit hfc_checker u_hfc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_ieee_word (out_ieee_word)
);
